// File: sv/pcmfap_pkg.sv
// ----------------------------------------------------------------------------
// pcmfap_pkg
// Shared constants, opcodes and the volume table of the PCM FIFO player.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmfap_pkg;

    localparam int FIFO_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = 13;

    localparam logic [ADDR_W-1:0] FILL_FULL = ADDR_W'(FIFO_DEPTH - 1);

    localparam logic [2:0] OP_WR_CTRL = 3'd0;
    localparam logic [2:0] OP_RD_CTRL = 3'd1;
    localparam logic [2:0] OP_WR_RATE = 3'd2;
    localparam logic [2:0] OP_RD_RATE = 3'd3;
    localparam logic [2:0] OP_PUSH    = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    localparam logic [1:0] FMT_MONO8    = 2'd0;
    localparam logic [1:0] FMT_STEREO8  = 2'd1;
    localparam logic [1:0] FMT_MONO16   = 2'd2;
    localparam logic [1:0] FMT_STEREO16 = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(1024);

    function automatic logic [6:0] gain_lookup(input logic [3:0] idx);
        logic [6:0] g;
        unique case (idx)
            4'd0:    g = 7'd0;
            4'd1:    g = 7'd1;
            4'd2:    g = 7'd2;
            4'd3:    g = 7'd3;
            4'd4:    g = 7'd4;
            4'd5:    g = 7'd5;
            4'd6:    g = 7'd6;
            4'd7:    g = 7'd8;
            4'd8:    g = 7'd11;
            4'd9:    g = 7'd14;
            4'd10:   g = 7'd18;
            4'd11:   g = 7'd23;
            4'd12:   g = 7'd30;
            4'd13:   g = 7'd38;
            4'd14:   g = 7'd49;
            default: g = 7'd64;
        endcase
        return g;
    endfunction

    // bytes a fetch takes, minus one
    function automatic logic [1:0] fetch_last(input logic [1:0] fmt);
        logic [1:0] n;
        unique case (fmt)
            FMT_MONO8:    n = 2'd0;
            FMT_STEREO8:  n = 2'd1;
            FMT_MONO16:   n = 2'd1;
            default:      n = 2'd3;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: sv/pcm_fifo_audio_player_core.sv
// ----------------------------------------------------------------------------
// pcm_fifo_audio_player_core
// PCM player with a byte FIFO in one synchronous RAM, bus-style commands and
// volume-scaled sample output.
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  s_        in         s_valid s_ready s_opcode s_data_byte
//  m_        out        m_valid m_ready m_read_data m_left_sample
//                       m_right_sample m_fill_low
//  cfg_      in         cfg_valid cfg_ready cfg_data (low-fill level)
//
//  Register and push commands follow back to back unless output stalls.
//  A tick passes ST_MUL and ST_OUT; with a fetch it first reads its bytes
//  (up to 4 for stereo 16-bit) over the single RAM read port, then ST_ASM.
//  Synchronous reset clears control state, level=LEVEL_RESET; RAM not cleared.
//  A stalled result holds in the output register; input waits meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_fifo_audio_player_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0]                    s_opcode,
    input  wire logic [7:0]                    s_data_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_read_data,
    output logic signed [15:0]                 m_left_sample,
    output logic signed [15:0]                 m_right_sample,
    output logic                               m_fill_low,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pcmfap_pkg::LEVEL_W-1:0] cfg_data
);
    import pcmfap_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_ASM  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [7:0] mem [FIFO_DEPTH];
    logic [7:0] mem_q_reg;
    logic       mem_we;
    logic       mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [5:0]        ctrl_reg, ctrl_next;
    logic              loop_reg, loop_next;
    logic [7:0]        rate_reg, rate_next;
    logic [7:0]        phase_reg, phase_next;
    logic signed [15:0] held_l_reg, held_l_next;
    logic signed [15:0] held_r_reg, held_r_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [1:0]        issue_reg, issue_next;
    logic [1:0]        last_reg, last_next;
    logic              pend_reg;
    logic [1:0]        slot_reg;
    logic [7:0]        byte_reg [4];
    logic [7:0]        bv [4];
    logic signed [23:0] prod_l_reg, prod_r_reg;
    logic signed [23:0] adj_l, adj_r;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  o_rd_reg, o_rd_next;
    logic signed [15:0] o_l_reg, o_l_next;
    logic signed [15:0] o_r_reg, o_r_next;
    logic        o_ae_reg, o_ae_next;

    logic        slot_free;
    logic        s_fire;
    logic [ADDR_W-1:0] fill_tmp, rd_tmp, wr_tmp;
    logic [1:0]  need_last;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid        = m_valid_reg;
    assign m_read_data    = o_rd_reg;
    assign m_left_sample  = o_l_reg;
    assign m_right_sample = o_r_reg;
    assign m_fill_low     = o_ae_reg;

    assign mem_we    = s_fire && (s_opcode == OP_PUSH) && (fill_reg != FILL_FULL);
    assign mem_re    = (state_reg == ST_READ);
    assign mem_raddr = base_reg + ADDR_W'(issue_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx_reg] <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // bytes as seen during assembly: the last one straight from the RAM
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            bv[i] = (pend_reg && (slot_reg == 2'(i))) ? mem_q_reg : byte_reg[i];
        end
    end

    assign adj_l = prod_l_reg + (prod_l_reg[23] ? 24'sd63 : 24'sd0);
    assign adj_r = prod_r_reg + (prod_r_reg[23] ? 24'sd63 : 24'sd0);

    always_comb begin
        state_next   = state_reg;
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        fill_next    = fill_reg;
        ctrl_next    = ctrl_reg;
        loop_next    = loop_reg;
        rate_next    = rate_reg;
        phase_next   = phase_reg;
        held_l_next  = held_l_reg;
        held_r_next  = held_r_reg;
        base_next    = base_reg;
        issue_next   = issue_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        o_rd_next    = o_rd_reg;
        o_l_next     = o_l_reg;
        o_r_next     = o_r_reg;
        o_ae_next    = o_ae_reg;
        fill_tmp     = fill_reg;
        rd_tmp       = rd_idx_reg;
        wr_tmp       = wr_idx_reg;
        need_last    = fetch_last(ctrl_reg[5:4]);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    o_rd_next = 8'd0;
                    o_l_next  = 16'sd0;
                    o_r_next  = 16'sd0;
                    unique case (s_opcode)
                        OP_WR_CTRL: begin
                            loop_next = s_data_byte[7] && s_data_byte[6];
                            if (s_data_byte[7] && !s_data_byte[6]) begin
                                wr_idx_next = '0;
                                rd_idx_next = '0;
                                fill_next   = '0;
                            end
                            if (s_data_byte[6]) begin
                                rd_idx_next = '0;
                                fill_next   = wr_idx_reg;
                            end
                            ctrl_next = s_data_byte[5:0];
                        end
                        OP_RD_CTRL: begin
                            o_rd_next = {fill_reg == FILL_FULL, fill_reg == '0, ctrl_reg};
                        end
                        OP_WR_RATE: begin
                            rate_next = (s_data_byte > 8'd128) ? (~s_data_byte + 8'd1)
                                                                : s_data_byte;
                        end
                        OP_RD_RATE: begin
                            o_rd_next = rate_reg;
                        end
                        OP_PUSH: begin
                            if (fill_reg != FILL_FULL) begin
                                wr_idx_next = wr_idx_reg + 1'b1;
                                fill_next   = fill_reg + 1'b1;
                            end
                        end
                        OP_TICK: begin
                            phase_next = phase_reg + rate_reg;
                            state_next = ST_MUL;
                            if (phase_next[7] != phase_reg[7]) begin
                                if (fill_reg == '0) begin
                                    held_l_next = 16'sd0;
                                    held_r_next = 16'sd0;
                                end else begin
                                    if ({1'b0, fill_reg} < {{(ADDR_W-1){1'b0}}, need_last}
                                                           + (ADDR_W+1)'(1)) begin
                                        // short data: flush, keep held samples
                                        rd_tmp   = wr_idx_reg;
                                        fill_tmp = '0;
                                    end else begin
                                        base_next  = rd_idx_reg;
                                        issue_next = 2'd0;
                                        last_next  = need_last;
                                        rd_tmp     = rd_idx_reg + ADDR_W'(need_last) + 1'b1;
                                        fill_tmp   = fill_reg - ADDR_W'(need_last) - 1'b1;
                                        state_next = ST_READ;
                                    end
                                    if (loop_reg && (fill_tmp == '0)) begin
                                        rd_tmp   = '0;
                                        fill_tmp = wr_tmp;
                                    end
                                    rd_idx_next = rd_tmp;
                                    fill_next   = fill_tmp;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (s_opcode != OP_TICK) begin
                        m_valid_next = 1'b1;
                        o_ae_next    = {1'b0, fill_next} < level_reg;
                    end
                end
            end
            ST_READ: begin
                issue_next = issue_reg + 2'd1;
                if (issue_reg == last_reg) begin
                    state_next = ST_ASM;
                end
            end
            ST_ASM: begin
                unique case (ctrl_reg[5:4])
                    FMT_MONO8: begin
                        held_l_next = {bv[0], 8'd0};
                        held_r_next = {bv[0], 8'd0};
                    end
                    FMT_STEREO8: begin
                        held_l_next = {bv[0], 8'd0};
                        held_r_next = {bv[1], 8'd0};
                    end
                    FMT_MONO16: begin
                        held_l_next = {bv[1], bv[0]};
                        held_r_next = {bv[1], bv[0]};
                    end
                    default: begin
                        held_l_next = {bv[1], bv[0]};
                        held_r_next = {bv[3], bv[2]};
                    end
                endcase
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    o_rd_next    = 8'd0;
                    o_l_next     = adj_l[21:6];
                    o_r_next     = adj_r[21:6];
                    o_ae_next    = {1'b0, fill_reg} < level_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            ctrl_reg    <= '0;
            loop_reg    <= 1'b0;
            rate_reg    <= '0;
            phase_reg   <= '0;
            held_l_reg  <= '0;
            held_r_reg  <= '0;
            level_reg   <= LEVEL_RESET;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            fill_reg    <= fill_next;
            ctrl_reg    <= ctrl_next;
            loop_reg    <= loop_next;
            rate_reg    <= rate_next;
            phase_reg   <= phase_next;
            held_l_reg  <= held_l_next;
            held_r_reg  <= held_r_next;
            pend_reg    <= mem_re;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                level_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        base_reg   <= base_next;
        issue_reg  <= issue_next;
        last_reg   <= last_next;
        slot_reg   <= issue_reg;
        o_rd_reg   <= o_rd_next;
        o_l_reg    <= o_l_next;
        o_r_reg    <= o_r_next;
        o_ae_reg   <= o_ae_next;
        prod_l_reg <= held_l_reg * $signed({1'b0, gain_lookup(ctrl_reg[3:0])});
        prod_r_reg <= held_r_reg * $signed({1'b0, gain_lookup(ctrl_reg[3:0])});
        if (pend_reg) begin
            byte_reg[slot_reg] <= mem_q_reg;
        end
    end

endmodule

`default_nettype wire
